/* design/refraction_direction_macros.svh */
// assertion macros for the refraction direction block
`ifndef REFRACTION_DIRECTION_MACROS_SVH
`define REFRACTION_DIRECTION_MACROS_SVH
`ifndef SYNTHESIS
`define RFD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RFD_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RFD_ASSERT(lbl, prop, msg)
`define RFD_ASSERT_RST(lbl, prop, msg)
`endif
`endif

/* design/rfd_pkg.sv */
// shared widths, constants and sideband type for the refraction direction block
`default_nettype none
package rfd_pkg;
    localparam int IN_W = 16;
    localparam int OUT_W = 20;
    localparam int PERP_W = 25;
    localparam int SQ_IN_W = 52;
    localparam int SQ_OUT_W = SQ_IN_W / 2;
    localparam int SQ_REM_W = SQ_OUT_W + 3;
    localparam logic signed [19:0] Q14_ONE = 20'sd16384;
    localparam logic signed [30:0] OUT_MAX = 31'sd524287;
    localparam logic signed [30:0] OUT_MIN = -31'sd524288;

    typedef struct packed {
        logic [2:0][PERP_W-1:0] perp;
        logic [2:0][IN_W-1:0]   nrm;
    } rfd_side_t;
endpackage
`default_nettype wire

/* design/refraction_direction.sv */
// refraction direction by snell's law, fully pipelined
// throughput: one request per cycle; the whole pipeline holds while the result is not taken
// the 26-stage square root sets the depth, one root bit per stage
// reset: asynchronous, active low, clears all valid bits; data registers are not reset
`default_nettype none
`include "refraction_direction_macros.svh"
module refraction_direction
    import rfd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // in_x, in_y, in_z, norm_x, norm_y, norm_z, index_ratio
    input  wire logic [111:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // out_x, out_y, out_z, zero fill
    output logic [63:0]       m_tdata
);
    logic en;
    assign en = !m_tvalid || m_tready;
    assign s_tready = en;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, va_reg, vb_reg;

    logic signed [IN_W-1:0] dir1_reg [3];
    logic signed [IN_W-1:0] nrm1_reg [3];
    logic [15:0]            eta1_reg;
    logic signed [31:0]     prod1_reg [3];

    logic signed [IN_W-1:0] dir2_reg [3];
    logic signed [IN_W-1:0] nrm2_reg [3];
    logic [15:0]            eta2_reg;
    logic signed [19:0]     cos2_reg;

    logic signed [IN_W-1:0] nrm3_reg [3];
    logic [15:0]            eta3_reg;
    logic signed [35:0]     t3_reg [3];

    logic signed [IN_W-1:0] nrm4_reg [3];
    logic signed [52:0]     m4_reg [3];

    logic signed [IN_W-1:0]   nrm5_reg [3];
    logic signed [PERP_W-1:0] perp5_reg [3];

    logic signed [IN_W-1:0]   nrm6_reg [3];
    logic signed [PERP_W-1:0] perp6_reg [3];
    logic [48:0]              sq6_reg [3];

    logic [SQ_IN_W-1:0] rad7_reg;
    rfd_side_t          side7_reg;

    logic                sq_valid;
    logic [SQ_OUT_W-1:0] sq_root;
    rfd_side_t           sq_side;

    logic signed [PERP_W-1:0] perpa_reg [3];
    logic signed [42:0]       proda_reg [3];
    logic [OUT_W-1:0]         outb_reg [3];

    logic signed [33:0] cos_ext;
    logic signed [19:0] cos_next;
    logic signed [35:0] t_next [3];
    logic signed [52:0] m_next [3];
    logic signed [PERP_W-1:0] perp_next [3];
    logic [48:0]        sq_next [3];
    logic [SQ_IN_W-1:0] rad_next;
    logic signed [42:0] prod_next [3];
    logic [OUT_W-1:0]   out_next [3];

    always_comb
    begin
        logic signed [33:0] dot;
        logic signed [51:0] len_diff;
        logic signed [43:0] par_full;
        logic signed [30:0] sum;
        logic signed [49:0] sq_full;
        dot = 34'(prod1_reg[0]) + 34'(prod1_reg[1]) + 34'(prod1_reg[2]);
        cos_ext = (-dot + 34'sd8192) >>> 14;
        cos_next = (cos_ext > 34'(Q14_ONE)) ? Q14_ONE : cos_ext[19:0];
        for (int k = 0; k < 3; k++)
        begin
            t_next[k] = (36'(dir2_reg[k]) <<< 14) + cos2_reg * nrm2_reg[k];
            m_next[k] = $signed({1'b0, eta3_reg}) * t3_reg[k];
            perp_next[k] = PERP_W'((m4_reg[k] + 53'sd134217728) >>> 28);
            sq_full = perp5_reg[k] * perp5_reg[k];
            sq_next[k] = sq_full[48:0];
            prod_next[k] = $signed({1'b0, sq_root}) * $signed(sq_side.nrm[k]);
            par_full = (-44'(proda_reg[k]) + 44'sd8192) >>> 14;
            sum = 31'(perpa_reg[k]) + 31'(par_full);
            if (sum > OUT_MAX)
            begin
                out_next[k] = OUT_MAX[OUT_W-1:0];
            end
            else if (sum < OUT_MIN)
            begin
                out_next[k] = OUT_MIN[OUT_W-1:0];
            end
            else
            begin
                out_next[k] = sum[OUT_W-1:0];
            end
        end
        len_diff = 52'sd268435456 - 52'(sq6_reg[0]) - 52'(sq6_reg[1]) - 52'(sq6_reg[2]);
        rad_next = (len_diff < 0) ? SQ_IN_W'(-len_diff) : SQ_IN_W'(len_diff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            va_reg <= sq_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            eta1_reg <= s_tdata[111:96];
            eta2_reg <= eta1_reg;
            eta3_reg <= eta2_reg;
            cos2_reg <= cos_next;
            rad7_reg <= rad_next;
            for (int k = 0; k < 3; k++)
            begin
                dir1_reg[k]  <= s_tdata[16*k +: 16];
                nrm1_reg[k]  <= s_tdata[48 + 16*k +: 16];
                prod1_reg[k] <= $signed(s_tdata[16*k +: 16]) * $signed(s_tdata[48 + 16*k +: 16]);
                dir2_reg[k]  <= dir1_reg[k];
                nrm2_reg[k]  <= nrm1_reg[k];
                nrm3_reg[k]  <= nrm2_reg[k];
                t3_reg[k]    <= t_next[k];
                nrm4_reg[k]  <= nrm3_reg[k];
                m4_reg[k]    <= m_next[k];
                nrm5_reg[k]  <= nrm4_reg[k];
                perp5_reg[k] <= perp_next[k];
                nrm6_reg[k]  <= nrm5_reg[k];
                perp6_reg[k] <= perp5_reg[k];
                sq6_reg[k]   <= sq_next[k];
                side7_reg.perp[k] <= perp6_reg[k];
                side7_reg.nrm[k]  <= nrm6_reg[k];
                perpa_reg[k] <= $signed(sq_side.perp[k]);
                proda_reg[k] <= prod_next[k];
                outb_reg[k]  <= out_next[k];
            end
        end
    end

    rfd_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v7_reg),
        .radicand  (rad7_reg),
        .in_side   (side7_reg),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_side  (sq_side)
    );

    assign m_tvalid = vb_reg;
    assign m_tdata  = {4'b0000, outb_reg[2], outb_reg[1], outb_reg[0]};

    `RFD_ASSERT(a_cos_capped, v2_reg |-> (cos2_reg <= Q14_ONE), "cosine above one")
    `RFD_ASSERT(a_idle_ready, !m_tvalid |-> s_tready, "not ready while output empty")
    `RFD_ASSERT_RST(a_reset_clears, !rst_n |-> !m_tvalid, "output valid during reset")
endmodule
`default_nettype wire

/* design/rfd_sqrt.sv */
// pipelined integer square root, one result bit per stage, with sideband
`default_nettype none
module rfd_sqrt
    import rfd_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire logic                in_valid,
    input  wire logic [SQ_IN_W-1:0]  radicand,
    input  wire rfd_side_t           in_side,
    output logic                     out_valid,
    output logic [SQ_OUT_W-1:0]      root,
    output rfd_side_t                out_side
);
    logic                vld_reg  [SQ_OUT_W+1];
    logic [SQ_REM_W-1:0] rem_reg  [SQ_OUT_W+1];
    logic [SQ_OUT_W-1:0] root_reg [SQ_OUT_W+1];
    logic [SQ_IN_W-1:0]  rad_reg  [SQ_OUT_W+1];
    rfd_side_t           side_reg [SQ_OUT_W+1];

    always_comb
    begin
        vld_reg[0]  = in_valid;
        rem_reg[0]  = '0;
        root_reg[0] = '0;
        rad_reg[0]  = radicand;
        side_reg[0] = in_side;
    end

    for (genvar i = 0; i < SQ_OUT_W; i++)
    begin : g_stage
        logic [SQ_REM_W-1:0] shifted;
        logic [SQ_REM_W-1:0] trial;
        logic [SQ_REM_W-1:0] rem_next;
        logic [SQ_OUT_W-1:0] root_next;

        always_comb
        begin
            shifted = {rem_reg[i][SQ_REM_W-3:0], rad_reg[i][SQ_IN_W-1 -: 2]};
            trial   = {1'b0, root_reg[i], 2'b01};
            if (shifted >= trial)
            begin
                rem_next  = shifted - trial;
                root_next = {root_reg[i][SQ_OUT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted;
                root_next = {root_reg[i][SQ_OUT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1]  <= rem_next;
                root_reg[i+1] <= root_next;
                rad_reg[i+1]  <= {rad_reg[i][SQ_IN_W-3:0], 2'b00};
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    assign out_valid = vld_reg[SQ_OUT_W];
    assign root      = root_reg[SQ_OUT_W];
    assign out_side  = side_reg[SQ_OUT_W];
endmodule
`default_nettype wire

/* sim/tb_refraction_direction.sv */
// testbench for the refraction direction block: random and directed rays checked against a predictor
`default_nettype none
module tb_refraction_direction;
    typedef struct packed {
        logic [15:0] ratio;
        logic [15:0] nz;
        logic [15:0] ny;
        logic [15:0] nx;
        logic [15:0] iz;
        logic [15:0] iy;
        logic [15:0] ix;
    } ray_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [111:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;

    ray_t         ray_q[$];
    logic [59:0]  dir_q[$];
    int           send_idle;
    int           recv_idle;
    int           hold_cycles;
    bit           feeding_done;
    int           errors;
    int           checked;

    refraction_direction u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic longint rnd_shift(input longint v, input int s);
        longint w;
        w = v + (longint'(1) << (s - 1));
        return w >>> s;
    endfunction

    function automatic longint root_floor(input longint a);
        longint r;
        longint b;
        r = 0;
        b = longint'(1) << 62;
        while (b > a)
            b = b >> 2;
        while (b != 0)
        begin
            if (a >= r + b)
            begin
                a = a - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [59:0] refract(input ray_t r);
        longint d[3];
        longint n[3];
        longint p[3];
        longint eta;
        longint dot;
        longint c;
        longint len2;
        longint diff;
        longint s;
        longint o;
        logic [59:0] res;
        d[0] = longint'(signed'(r.ix));
        d[1] = longint'(signed'(r.iy));
        d[2] = longint'(signed'(r.iz));
        n[0] = longint'(signed'(r.nx));
        n[1] = longint'(signed'(r.ny));
        n[2] = longint'(signed'(r.nz));
        eta = longint'(r.ratio);
        dot = d[0] * n[0] + d[1] * n[1] + d[2] * n[2];
        c = rnd_shift(-dot, 14);
        if (c > 16384)
            c = 16384;
        len2 = 0;
        for (int k = 0; k < 3; k++)
        begin
            p[k] = rnd_shift(eta * (d[k] * 16384 + c * n[k]), 28);
            len2 += p[k] * p[k];
        end
        diff = (longint'(1) << 28) - len2;
        if (diff < 0)
            diff = -diff;
        s = root_floor(diff);
        for (int k = 0; k < 3; k++)
        begin
            o = p[k] + rnd_shift(-s * n[k], 14);
            if (o > 524287)
                o = 524287;
            if (o < -524288)
                o = -524288;
            res[k*20 +: 20] = o[19:0];
        end
        return res;
    endfunction

    function automatic logic [15:0] rnd_unit();
        return 16'(int'($urandom_range(32768)) - 16384);
    endfunction

    // random ray: mostly unit-ish vectors scaled to length near one, some with raw random components or ratio
    function automatic ray_t rnd_ray();
        ray_t r;
        real l;
        real v[6];
        int mode;
        mode = $urandom_range(9);
        for (int k = 0; k < 6; k++)
            v[k] = (real'($urandom_range(20000)) - 10000.0) / 10000.0;
        for (int g = 0; g < 2; g++)
        begin
            l = $sqrt(v[3*g]**2 + v[3*g+1]**2 + v[3*g+2]**2);
            if (l < 0.01)
                l = 1.0;
            for (int k = 0; k < 3; k++)
                v[3*g+k] = v[3*g+k] / l * 16384.0;
        end
        r.ix = 16'($rtoi(v[0]));
        r.iy = 16'($rtoi(v[1]));
        r.iz = 16'($rtoi(v[2]));
        r.nx = 16'($rtoi(v[3]));
        r.ny = 16'($rtoi(v[4]));
        r.nz = 16'($rtoi(v[5]));
        r.ratio = 16'($urandom_range(8192, 32768));
        if (mode == 0)
        begin
            r.ix = rnd_unit(); r.iy = rnd_unit(); r.iz = rnd_unit();
            r.nx = rnd_unit(); r.ny = rnd_unit(); r.nz = rnd_unit();
        end
        if (mode == 1)
            r = ray_t'({$urandom, $urandom, $urandom, 16'($urandom)});
        if (mode >= 8)
            r.ratio = 16'($urandom);
        return r;
    endfunction

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (ray_q.size() > 0 && ($urandom_range(99) >= send_idle))
            begin
                dir_q.push_back(refract(ray_q[0]));
                s_tdata  <= ray_q.pop_front();
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle);
    end

    // result check
    always @(posedge clk)
    begin
        logic [59:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (dir_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %h", m_tdata);
            end
            else
            begin
                want = dir_q.pop_front();
                checked++;
                for (int k = 0; k < 3; k++)
                    if (m_tdata[k*20 +: 20] !== want[k*20 +: 20])
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("out%0d mismatch: expected %0d got %0d", k,
                                     signed'(want[k*20 +: 20]), signed'(m_tdata[k*20 +: 20]));
                    end
            end
        end
    end

    task automatic push(input logic [15:0] ix, iy, iz, nx, ny, nz, ratio);
        ray_t r;
        r = '{ratio, nz, ny, nx, iz, iy, ix};
        ray_q.push_back(r);
    endtask

    task automatic drain();
        while (ray_q.size() > 0 || s_tvalid || dir_q.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        errors = 0;
        checked = 0;
        hold_cycles = 0;
        send_idle = 16;
        recv_idle = 79;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        // directed: extremes, head-on, grazing, zero ratio, reflection, overflow
        push(16'h0000, 16'hc000, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h4000);
        push(16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h6000);
        push(16'h2d41, 16'hd2bf, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000);
        push(16'h2d41, 16'hd2bf, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'hffff);
        push(16'h3ee0, 16'hf000, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h8000);
        push(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'hffff);
        push(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hffff);
        push(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'hffff);
        push(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        push(16'hc000, 16'h0000, 16'h0000, 16'hc000, 16'h0000, 16'h0000, 16'h4000);
        push(16'h4000, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h4000);
        push(16'hffff, 16'h0001, 16'h5555, 16'haaaa, 16'h0001, 16'hffff, 16'h0001);
        push(16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'hc000, 16'h2000);
        drain();
        for (int ph = 0; ph < 3; ph++)
        begin
            for (int i = 0; i < 210; i++)
                ray_q.push_back(rnd_ray());
            if (ph == 2)
                hold_cycles = 120;
            drain();
            send_idle = (ph == 0) ? 79 : 0;
            recv_idle = (ph == 0) ? 16 : 0;
        end
        repeat (60) @(posedge clk);
        $display("checked %0d refracted rays: directed edge cases, unit and raw random vectors,",
                 checked);
        $display("under three idle mixes and a long output stall");
        if (errors == 0)
            $display("PASS refraction_direction");
        else
            $display("FAIL refraction_direction");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("FAIL refraction_direction");
        $finish;
    end
endmodule
`default_nettype wire
